// File: src/io_port_permission_bitmap_unit_defines.svh
// Assertion macros for the port permission bitmap RTL
`ifndef IO_PORT_PERMISSION_BITMAP_UNIT_DEFINES_SVH
`define IO_PORT_PERMISSION_BITMAP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/io_pbm_pkg.sv
// Types and constants of the I/O port permission bitmap unit
`timescale 1ns / 1ps
`default_nettype none

package io_pbm_pkg;

  // Command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_RANGE  = 2'd1;
  localparam logic [1:0] STATUS_NOT_PERMIT = 2'd2;

  typedef struct packed {
    logic        command;
    logic [15:0] first_port;
    logic [16:0] port_count;
    logic        enable_access;
    logic        has_rawio_privilege;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       port_denied;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_FIX,
    S_READ,
    S_WALK,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic clr_step;
    logic load_idx;
    logic rd_en;
    logic rd_next;
    logic walk;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic query_oor;
    logic range_bad;
    logic perm_bad;
    logic at_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: src/io_port_permission_bitmap_unit.sv
// An update passes through the states MUL, FIX and READ, then walks the W bitmap words it touches, and ends in DONE.
// A query passes through MUL, FIX and READ to DONE; a rejected update or an out-of-range query skips READ.
// One item at a time: the next input is taken once the result sits in the output register.
// The word walk does one word update per cycle.
// After reset a clearing pass sets every deny bit.
// Top level of the I/O port permission bitmap unit
`timescale 1ns / 1ps
`default_nettype none

module io_port_permission_bitmap_unit #(
  parameter int PORT_COUNT = 1024,
  parameter int WORD_BITS  = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire io_pbm_pkg::in_item_t  in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output io_pbm_pkg::out_item_t      out_item_o
);

  io_pbm_pkg::ctrl_cmd_t cmd;
  io_pbm_pkg::dp_stat_t  stat;

  io_pbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  io_pbm_dp #(
    .PORT_COUNT (PORT_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: src/io_pbm_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module io_pbm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: src/io_pbm_dp.sv
// Datapath: item registers, word/bit split, edge masks, bitmap RAM and result register
`timescale 1ns / 1ps
`default_nettype none

module io_pbm_dp #(
  parameter int PORT_COUNT = 1024,
  parameter int WORD_BITS  = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire io_pbm_pkg::in_item_t in_item_i,
  input  wire io_pbm_pkg::ctrl_cmd_t cmd_i,
  input  wire logic                 out_stall_i,
  output io_pbm_pkg::dp_stat_t      stat_o,
  output logic                      out_valid_o,
  output io_pbm_pkg::out_item_t     out_item_o
);

  localparam int MAP_WORDS = (PORT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LW        = $clog2(WORD_BITS);
  // Reciprocal for an exact 16-bit quotient by WORD_BITS
  localparam int SHIFT     = 16 + LW;
  localparam int RECIP     = ((2 ** SHIFT) + WORD_BITS - 1) / WORD_BITS;

  // Quotient and remainder of a 16-bit port number, from its reciprocal product
  function automatic logic [16+LW-1:0] split_port(input logic [15:0] port,
                                                  input logic [32:0] prod);
    logic [15:0] quo;
    logic [15:0] rem;
    quo = 16'(prod >> SHIFT);
    rem = port - 16'(quo * 16'(WORD_BITS));
    if (rem >= 16'(WORD_BITS)) begin
      quo = quo + 16'd1;
      rem = rem - 16'(WORD_BITS);
    end
    return {quo, rem[LW-1:0]};
  endfunction

  io_pbm_pkg::in_item_t item_q;

  logic [17:0]          end_sum;
  logic [15:0]          last_port;
  logic [32:0]          prod_first_q;
  logic [32:0]          prod_last_q;
  logic [32:0]          prod_first_d;
  logic [32:0]          prod_last_d;
  logic [16+LW-1:0]     split_first;
  logic [16+LW-1:0]     split_last;
  logic [AW-1:0]        wcur_q, wcur_d;
  logic [AW-1:0]        wlast_q;
  logic [LW-1:0]        lo_q;
  logic [LW-1:0]        hi_q;
  logic                 first_word_q, first_word_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [WORD_BITS-1:0] ram_wr_data;
  logic [AW-1:0]        ram_rd_addr;
  logic [WORD_BITS-1:0] ram_rd_data;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] edge_mask;
  logic [WORD_BITS-1:0] upd_word;
  logic                 query_oor;
  logic                 range_bad;
  logic                 perm_bad;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  io_pbm_pkg::out_item_t out_item_q;
  io_pbm_pkg::out_item_t result;

  // Item capture on input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
  end

  // Range and permission checks
  assign end_sum   = 18'(item_q.first_port) + 18'(item_q.port_count);
  assign last_port = 16'(end_sum - 18'd1);
  assign range_bad = (item_q.port_count == 17'd0) || (end_sum > 18'(PORT_COUNT));
  assign perm_bad  = item_q.enable_access && !item_q.has_rawio_privilege;
  assign query_oor = {1'b0, item_q.first_port} >= 17'(PORT_COUNT);

  // Reciprocal products, one register stage
  assign prod_first_d = 33'(item_q.first_port) * 33'(RECIP);
  assign prod_last_d  = 33'(last_port) * 33'(RECIP);

  always_ff @(posedge clk_i) begin
    prod_first_q <= prod_first_d;
    prod_last_q  <= prod_last_d;
  end

  assign split_first = split_port(item_q.first_port, prod_first_q);
  assign split_last  = split_port(last_port, prod_last_q);

  // Word walk indices and edge offsets
  always_comb begin
    wcur_d       = wcur_q;
    first_word_d = first_word_q;
    if (cmd_i.load_idx) begin
      wcur_d       = AW'(split_first[16+LW-1:LW]);
      first_word_d = 1'b1;
    end else if (cmd_i.walk) begin
      wcur_d       = wcur_q + AW'(1);
      first_word_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    wcur_q       <= wcur_d;
    first_word_q <= first_word_d;
    if (cmd_i.load_idx) begin
      wlast_q <= AW'(split_last[16+LW-1:LW]);
      lo_q    <= split_first[LW-1:0];
      hi_q    <= split_last[LW-1:0];
    end
  end

  // Clearing pass address
  assign clr_d = cmd_i.clr_step ? clr_q + AW'(1) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // Edge masks and the updated word
  assign lo_mask   = {WORD_BITS{1'b1}} << lo_q;
  assign hi_mask   = {WORD_BITS{1'b1}} >> (LW'(WORD_BITS - 1) - hi_q);
  assign edge_mask = (first_word_q ? lo_mask : {WORD_BITS{1'b1}}) &
                     ((wcur_q == wlast_q) ? hi_mask : {WORD_BITS{1'b1}});
  assign upd_word  = item_q.enable_access ? (ram_rd_data & ~edge_mask)
                                          : (ram_rd_data | edge_mask);

  // Bitmap RAM ports
  assign ram_wr_en   = cmd_i.clr_step || cmd_i.walk;
  assign ram_wr_addr = cmd_i.clr_step ? clr_q : wcur_q;
  assign ram_wr_data = cmd_i.clr_step ? {WORD_BITS{1'b1}} : upd_word;
  assign ram_rd_addr = cmd_i.rd_next ? wcur_q + AW'(1) : wcur_q;

  io_pbm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Result formation
  always_comb begin
    result.status      = io_pbm_pkg::STATUS_OK;
    result.port_denied = 1'b0;
    if (item_q.command == io_pbm_pkg::CMD_QUERY) begin
      result.port_denied = query_oor | ram_rd_data[lo_q];
    end else if (range_bad) begin
      result.status = io_pbm_pkg::STATUS_BAD_RANGE;
    end else if (perm_bad) begin
      result.status = io_pbm_pkg::STATUS_NOT_PERMIT;
    end
  end

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Status to the controller
  assign stat_o.clr_last  = (clr_q == AW'(MAP_WORDS - 1));
  assign stat_o.is_query  = (item_q.command == io_pbm_pkg::CMD_QUERY);
  assign stat_o.query_oor = query_oor;
  assign stat_o.range_bad = range_bad;
  assign stat_o.perm_bad  = perm_bad;
  assign stat_o.at_last   = (wcur_q == wlast_q);
  assign stat_o.out_free  = out_free;

endmodule

`default_nettype wire

// File: src/io_pbm_ctrl.sv
// Controller: clearing pass, item sequencing, word walk and result hand-off
`timescale 1ns / 1ps
`default_nettype none
`include "io_port_permission_bitmap_unit_defines.svh"

module io_pbm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire io_pbm_pkg::dp_stat_t stat_i,
  output io_pbm_pkg::ctrl_cmd_t     cmd_o
);

  io_pbm_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= io_pbm_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      io_pbm_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = io_pbm_pkg::S_IDLE;
        end
      end
      io_pbm_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = io_pbm_pkg::S_MUL;
        end
      end
      io_pbm_pkg::S_MUL: begin
        state_d = io_pbm_pkg::S_FIX;
      end
      io_pbm_pkg::S_FIX: begin
        cmd_o.load_idx = 1'b1;
        if (stat_i.is_query) begin
          state_d = stat_i.query_oor ? io_pbm_pkg::S_DONE : io_pbm_pkg::S_READ;
        end else if (stat_i.range_bad || stat_i.perm_bad) begin
          state_d = io_pbm_pkg::S_DONE;
        end else begin
          state_d = io_pbm_pkg::S_READ;
        end
      end
      io_pbm_pkg::S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = stat_i.is_query ? io_pbm_pkg::S_DONE : io_pbm_pkg::S_WALK;
      end
      io_pbm_pkg::S_WALK: begin
        // write back this word and, unless it is the last, fetch the next one
        cmd_o.walk = 1'b1;
        if (stat_i.at_last) begin
          state_d = io_pbm_pkg::S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
        end
      end
      io_pbm_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = io_pbm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = io_pbm_pkg::S_IDLE;
      end
    endcase
  end

  // Checks
  `PBM_ASSERT_NOW(a_no_accept_in_clear, state_q == io_pbm_pkg::S_CLEAR, in_stall_o, "item taken during clearing pass")
  `PBM_ASSERT_NOW(a_load_only_free, cmd_o.out_load, stat_i.out_free, "result overwrote a pending transfer")
  `PBM_ASSERT_NEXT(a_done_to_idle, (state_q == io_pbm_pkg::S_DONE) && stat_i.out_free, state_q == io_pbm_pkg::S_IDLE, "result hand-off did not return to idle")
  `PBM_ASSERT_NEXT(a_walk_continues, (state_q == io_pbm_pkg::S_WALK) && !stat_i.at_last, state_q == io_pbm_pkg::S_WALK, "word walk stopped early")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the I/O port permission bitmap unit
`timescale 1ns / 1ps

module tb_top;

  localparam int PORT_COUNT  = 1024;
  localparam int WORD_BITS   = 64;
  localparam int MAP_WORDS   = (PORT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1650;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  io_pbm_pkg::in_item_t  in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  io_pbm_pkg::out_item_t out_item_o;

  // Predicted deny bitmap, one bit per port
  logic [WORD_BITS-1:0] deny_words [MAP_WORDS];

  io_pbm_pkg::out_item_t awaited_results[$];
  int        fail_count  = 0;
  int        cycle_count = 0;
  bit        idle_on     = 1'b0;
  int        hold_left   = 0;
  int        burst_left  = 0;

  io_port_permission_bitmap_unit #(
    .PORT_COUNT(PORT_COUNT),
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Apply one request to the predicted bitmap and return the result it gives
  function automatic io_pbm_pkg::out_item_t apply_port_request(io_pbm_pkg::in_item_t it);
    io_pbm_pkg::out_item_t r;
    int unsigned first;
    int unsigned last;
    first = it.first_port;
    last  = first + int'(it.port_count);
    r     = '0;
    if (it.command == io_pbm_pkg::CMD_QUERY) begin
      if (first < PORT_COUNT)
        r.port_denied = deny_words[first / WORD_BITS][first % WORD_BITS];
      else
        r.port_denied = 1'b1;
    end else if (it.port_count == 0 || last > PORT_COUNT) begin
      r.status = io_pbm_pkg::STATUS_BAD_RANGE;
    end else if (it.enable_access && !it.has_rawio_privilege) begin
      r.status = io_pbm_pkg::STATUS_NOT_PERMIT;
    end else begin
      for (int unsigned p = first; p < last; p++)
        deny_words[p / WORD_BITS][p % WORD_BITS] = !it.enable_access;
    end
    return r;
  endfunction

  function automatic io_pbm_pkg::in_item_t make_item(logic cmd, int unsigned first,
                                                     int unsigned count,
                                                     logic grant, logic priv);
    io_pbm_pkg::in_item_t it;
    it.command             = cmd;
    it.first_port          = first[15:0];
    it.port_count          = count[16:0];
    it.enable_access       = grant;
    it.has_rawio_privilege = priv;
    return it;
  endfunction

  // Mostly well-formed ranges and in-map queries, with some rejects and noise
  function automatic io_pbm_pkg::in_item_t random_item();
    int unsigned pick;
    int unsigned first;
    int unsigned count;
    int unsigned room;
    logic        grant;
    logic        priv;
    pick  = $urandom_range(0, 99);
    grant = 1'($urandom_range(0, 1));
    priv  = ($urandom_range(0, 4) != 0);
    first = $urandom_range(0, PORT_COUNT - 1);
    room  = PORT_COUNT - first;
    if (pick < 45) begin
      if ($urandom_range(0, 9) == 0)
        first = $urandom_range(0, 65535);
      return make_item(io_pbm_pkg::CMD_QUERY, first, $urandom_range(0, 131071), grant, priv);
    end
    if (pick < 88) begin
      if ($urandom_range(0, 3) == 0)
        count = $urandom_range(1, room);
      else
        count = $urandom_range(1, (room < 130) ? room : 130);
    end else begin
      case ($urandom_range(0, 3))
        0: count = 0;
        1: count = room + $urandom_range(1, 200);
        2: count = 65536;
        default: begin
          first = $urandom_range(0, 65535);
          count = $urandom_range(0, 131071);
        end
      endcase
    end
    return make_item(io_pbm_pkg::CMD_UPDATE, first, count, grant, priv);
  endfunction

  // One input transfer; called and returns on a rising edge
  task automatic send_item(io_pbm_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(apply_port_request(it));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Receiver stall: long hold-offs on request, else random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall_i <= 1'b1;
        burst_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (idle_on && $urandom_range(0, 7) == 0)
          burst_left = $urandom_range(1, 18);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    io_pbm_pkg::out_item_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d port_denied %0d",
               out_item_o.status, out_item_o.port_denied);
        fail_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (out_item_o.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_item_o.status);
          fail_count++;
        end
        if (out_item_o.port_denied !== exp_r.port_denied) begin
          $error("port_denied: expected %0d, got %0d",
                 exp_r.port_denied, out_item_o.port_denied);
          fail_count++;
        end
      end
    end
  end

  // Every port reads as denied after reset, including ports past the map
  task automatic test_reset_state();
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 63, 0, 1'b0, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 64, 0, 1'b1, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, PORT_COUNT - 1, 'h1ffff, 1'b1, 1'b1));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, PORT_COUNT, 0, 1'b0, 1'b1));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 65535, 'h1ffff, 1'b1, 1'b1));
  endtask

  // Rejected ranges, privilege checks and word-edge grants and revokes
  task automatic test_directed_ranges();
    send_item(make_item(io_pbm_pkg::CMD_UPDATE, 5, 0, 1'b1, 1'b1));
    send_item(make_item(io_pbm_pkg::CMD_UPDATE, 1000, 25, 1'b1, 1'b1));
    send_item(make_item(io_pbm_pkg::CMD_UPDATE, 0, 65536, 1'b1, 1'b1));
    send_item(make_item(io_pbm_pkg::CMD_UPDATE, 65535, 1, 1'b0, 1'b1));
    send_item(make_item(io_pbm_pkg::CMD_UPDATE, 60, 10, 1'b1, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 63, 0, 1'b0, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_UPDATE, 60, 10, 1'b1, 1'b1));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 59, 0, 1'b0, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 60, 0, 1'b0, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 69, 0, 1'b0, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 70, 0, 1'b0, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_UPDATE, 0, PORT_COUNT, 1'b1, 1'b1));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, PORT_COUNT - 1, 0, 1'b0, 1'b0));
    // revoke needs no privilege
    send_item(make_item(io_pbm_pkg::CMD_UPDATE, 1, PORT_COUNT - 2, 1'b0, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, 1, 0, 1'b0, 1'b0));
    send_item(make_item(io_pbm_pkg::CMD_UPDATE, PORT_COUNT - 1, 1, 1'b0, 1'b1));
    send_item(make_item(io_pbm_pkg::CMD_QUERY, PORT_COUNT - 1, 0, 1'b0, 1'b0));
  endtask

  // Receiver holds off while the sender keeps offering, then the sender pauses
  task automatic test_backpressure();
    hold_left = 300;
    for (int i = 0; i < 8; i++)
      send_item(random_item());
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = (i < RANDOM_ITEMS - 300) && ((i / 150) % 3 != 2);
      send_item(random_item());
      if (i == RANDOM_ITEMS / 2)
        drain_results();
    end
  endtask

  initial begin
    for (int w = 0; w < MAP_WORDS; w++)
      deny_words[w] = '1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_ranges();
    drain_results();
    idle_on = 1'b1;
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
